// ===== rtl/core/agl_pkg.sv =====
`timescale 1ns / 1ps
// Package for the adjacency list graph store: sizes, command and status codes,
// request/response payload types and memory port bundles. No dependencies.
package agl_pkg;

   localparam int MAX_VERTICES    = 64;
   localparam int LIST_DEPTH      = 64;
   localparam int RESULT_LIMIT    = 64;

   localparam int VALUE_BITS      = 7;
   localparam int VERTEX_BITS     = $clog2(MAX_VERTICES);
   localparam int SLOT_BITS       = $clog2(LIST_DEPTH);
   localparam int LEN_BITS        = $clog2(LIST_DEPTH + 1);
   localparam int ENTRY_ADDR_BITS = VERTEX_BITS + SLOT_BITS;
   localparam int COUNT_BITS      = $clog2(RESULT_LIMIT + 1);

   localparam logic [2:0] KIND_CLEAR  = 3'd0;
   localparam logic [2:0] KIND_ADD    = 3'd1;
   localparam logic [2:0] KIND_ADJ    = 3'd2;
   localparam logic [2:0] KIND_DEGREE = 3'd3;
   localparam logic [2:0] KIND_LIST   = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [2:0]            kind;
      logic [VALUE_BITS-1:0] first_vertex;
      logic [VALUE_BITS-1:0] second_vertex;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [1:0]            status;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic                       wr_en;
      logic [ENTRY_ADDR_BITS-1:0] wr_addr;
      logic [VALUE_BITS-1:0]      wr_data;
      logic [ENTRY_ADDR_BITS-1:0] rd_addr;
   } ent_port_type;

   typedef struct packed {
      logic                   wr_en;
      logic [VERTEX_BITS-1:0] wr_addr;
      logic [LEN_BITS-1:0]    wr_data;
      logic [VERTEX_BITS-1:0] rd_addr;
   } len_port_type;

endpackage

// ===== rtl/core/agl_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port synchronous RAM.
// Read data is registered. No dependencies.
module agl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/agl_seq.sv =====
`timescale 1ns / 1ps
// Command sequencer: decodes requests, drives the length and entry memories,
// scans lists, builds and walks the neighbor map. Depends on agl_pkg.
module agl_seq import agl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   input  logic [VALUE_BITS-1:0] active_count,
   output ent_port_type          ent_port,
   input  logic [VALUE_BITS-1:0] ent_rd_data,
   output len_port_type          len_port,
   input  logic [LEN_BITS-1:0]   len_rd_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CHECK = 8'b0000_0010,
      S_LENA  = 8'b0000_0100,
      S_LENB  = 8'b0000_1000,
      S_APP2  = 8'b0001_0000,
      S_APP3  = 8'b0010_0000,
      S_SCAN  = 8'b0100_0000,
      S_WALK  = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   req_type                 cmd_ff, cmd_in;
   logic [LEN_BITS-1:0]     len_a_ff, len_a_in;
   logic [LEN_BITS-1:0]     len_b_ff, len_b_in;
   logic [LEN_BITS-1:0]     idx_ff, idx_in;
   logic [MAX_VERTICES-1:0] len_valid_ff, len_valid_in;
   logic [MAX_VERTICES-1:0] nbr_map_ff, nbr_map_in;
   logic [VERTEX_BITS-1:0]  walk_ff, walk_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   logic [VALUE_BITS-1:0]   a_m1, b_m1, d_m1;
   logic [VERTEX_BITS-1:0]  a_idx, b_idx, d_idx;
   logic                    a_ok, b_ok, d_ok, self_loop;
   logic [LEN_BITS-1:0]     len_a_rd, len_b_rd;
   logic [LEN_BITS:0]       len_a_two;
   logic                    edge_full;
   logic                    scan_done;
   logic [LEN_BITS-1:0]     len_a_inc, len_b_inc;
   logic [MAX_VERTICES-1:0] map_rest;
   logic                    walk_fin;

   function automatic rsp_type make_rsp(input logic [VALUE_BITS-1:0] value,
                                        input logic [1:0] status, input logic last);
      rsp_type r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      return r;
   endfunction

   assign a_m1      = cmd_ff.first_vertex - VALUE_BITS'(1);
   assign b_m1      = cmd_ff.second_vertex - VALUE_BITS'(1);
   assign d_m1      = ent_rd_data - VALUE_BITS'(1);
   assign a_idx     = a_m1[VERTEX_BITS-1:0];
   assign b_idx     = b_m1[VERTEX_BITS-1:0];
   assign d_idx     = d_m1[VERTEX_BITS-1:0];
   assign a_ok      = (cmd_ff.first_vertex != '0) && (cmd_ff.first_vertex <= active_count);
   assign b_ok      = (cmd_ff.second_vertex != '0) && (cmd_ff.second_vertex <= active_count);
   assign d_ok      = (ent_rd_data != '0) && (ent_rd_data <= active_count);
   assign self_loop = (cmd_ff.first_vertex == cmd_ff.second_vertex);

   assign len_a_rd  = len_valid_ff[a_idx] ? len_rd_data : '0;
   assign len_b_rd  = len_valid_ff[b_idx] ? len_rd_data : '0;
   assign len_a_two = {1'b0, len_a_ff} + (LEN_BITS+1)'(2);
   assign len_a_inc = len_a_ff + LEN_BITS'(1);
   assign len_b_inc = len_b_ff + LEN_BITS'(1);
   assign edge_full = self_loop ? (len_a_two > (LEN_BITS+1)'(LIST_DEPTH))
                    : ((len_a_ff >= LEN_BITS'(LIST_DEPTH)) ||
                       (len_b_rd >= LEN_BITS'(LIST_DEPTH)));
   assign scan_done = (idx_ff == len_a_ff);

   always_comb begin
      map_rest = nbr_map_ff;
      map_rest[walk_ff] = 1'b0;
   end
   assign walk_fin = (map_rest == '0) || (count_ff == COUNT_BITS'(RESULT_LIMIT - 1));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      len_a_in      = len_a_ff;
      len_b_in      = len_b_ff;
      idx_in        = idx_ff;
      len_valid_in  = len_valid_ff;
      nbr_map_in    = nbr_map_ff;
      walk_in       = walk_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      ent_port      = '0;
      len_port      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            len_port.rd_addr = a_idx;
            unique case (cmd_ff.kind) inside
               KIND_CLEAR: begin
                  len_valid_in  = '0;
                  rsp_in        = make_rsp('0, STATUS_OK, 1'b1);
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
               KIND_ADD, KIND_ADJ: begin
                  if (a_ok && b_ok) begin
                     state_in = S_LENA;
                  end else begin
                     rsp_in        = make_rsp('0, STATUS_RANGE, 1'b1);
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               KIND_DEGREE, KIND_LIST: begin
                  if (a_ok) begin
                     state_in = S_LENA;
                  end else begin
                     rsp_in        = make_rsp('0, STATUS_RANGE, 1'b1);
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LENA: begin
            len_a_in   = len_a_rd;
            nbr_map_in = '0;
            walk_in    = '0;
            count_in   = '0;
            idx_in     = LEN_BITS'(1);
            unique case (cmd_ff.kind)
               KIND_ADD: begin
                  len_port.rd_addr = b_idx;
                  state_in         = S_LENB;
               end
               KIND_DEGREE: begin
                  rsp_in        = make_rsp(VALUE_BITS'(len_a_rd), STATUS_OK, 1'b1);
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
               default: begin
                  ent_port.rd_addr = {a_idx, SLOT_BITS'(0)};
                  if (len_a_rd == '0) begin
                     rsp_in = make_rsp('0, (cmd_ff.kind == KIND_LIST) ? STATUS_EMPTY
                                                                     : STATUS_OK, 1'b1);
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            endcase
         end
         S_LENB: begin
            len_b_in = len_b_rd;
            if (edge_full) begin
               rsp_in        = make_rsp('0, STATUS_FULL, 1'b1);
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               ent_port.wr_en   = 1'b1;
               ent_port.wr_addr = {a_idx, len_a_ff[SLOT_BITS-1:0]};
               ent_port.wr_data = cmd_ff.second_vertex;
               state_in         = S_APP2;
            end
         end
         S_APP2: begin
            ent_port.wr_en    = 1'b1;
            ent_port.wr_data  = cmd_ff.first_vertex;
            len_port.wr_en    = 1'b1;
            len_port.wr_addr  = a_idx;
            len_valid_in[a_idx] = 1'b1;
            if (self_loop) begin
               ent_port.wr_addr = {a_idx, len_a_inc[SLOT_BITS-1:0]};
               len_port.wr_data = len_a_two[LEN_BITS-1:0];
            end else begin
               ent_port.wr_addr = {b_idx, len_b_ff[SLOT_BITS-1:0]};
               len_port.wr_data = len_a_inc;
            end
            state_in = S_APP3;
         end
         S_APP3: begin
            if (!self_loop) begin
               len_port.wr_en      = 1'b1;
               len_port.wr_addr    = b_idx;
               len_port.wr_data    = len_b_inc;
               len_valid_in[b_idx] = 1'b1;
            end
            rsp_in        = make_rsp('0, STATUS_OK, 1'b1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_SCAN: begin
            ent_port.rd_addr = {a_idx, idx_ff[SLOT_BITS-1:0]};
            idx_in           = idx_ff + LEN_BITS'(1);
            if (cmd_ff.kind == KIND_ADJ) begin
               if (ent_rd_data == cmd_ff.second_vertex) begin
                  rsp_in        = make_rsp(VALUE_BITS'(1), STATUS_OK, 1'b1);
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end else if (scan_done) begin
                  rsp_in        = make_rsp('0, STATUS_OK, 1'b1);
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               if (d_ok) begin
                  nbr_map_in[d_idx] = 1'b1;
               end
               if (scan_done) begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            walk_in = walk_ff + VERTEX_BITS'(1);
            if (nbr_map_ff == '0) begin
               rsp_in        = make_rsp('0, STATUS_EMPTY, 1'b1);
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (nbr_map_ff[walk_ff]) begin
               nbr_map_in    = map_rest;
               count_in      = count_ff + COUNT_BITS'(1);
               rsp_in        = make_rsp(VALUE_BITS'(walk_ff) + VALUE_BITS'(1), STATUS_OK,
                                        walk_fin);
               rsp_strobe_in = 1'b1;
               if (walk_fin) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_valid_ff  <= len_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff     <= cmd_in;
      len_a_ff   <= len_a_in;
      len_b_ff   <= len_b_in;
      idx_ff     <= idx_in;
      nbr_map_ff <= nbr_map_in;
      walk_ff    <= walk_in;
      count_ff   <= count_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/core/adjacency_list_graph_store_core.sv =====
`timescale 1ns / 1ps
// Adjacency list graph store: one request per start, busy until its last response
// (an unknown kind goes idle with none). Degree answers from the length read; an
// adjacency test or neighbor listing scans the list, one entry-memory read per cycle
// setting the scan rate, and a listing then walks the vertex map. Next request is taken
// at the edge that accepts the last response; the strobe lasts one cycle and cannot be
// stalled. Sync reset empties all lists (valid bits), vertex_count 64.
module adjacency_list_graph_store_core import agl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   input  logic                  csr_write_enable,
   input  logic [VALUE_BITS-1:0] csr_write_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data
);

   logic [VALUE_BITS-1:0] vertex_count_ff, vertex_count_in;
   logic [VALUE_BITS-1:0] active_count;
   ent_port_type          ent_port;
   len_port_type          len_port;
   logic [VALUE_BITS-1:0] ent_rd_data;
   logic [LEN_BITS-1:0]   len_rd_data;

   assign vertex_count_in = csr_write_enable ? csr_write_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VALUE_BITS'(64);
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   assign active_count = (vertex_count_ff == '0) ? VALUE_BITS'(1)
                       : (vertex_count_ff > VALUE_BITS'(MAX_VERTICES)) ? VALUE_BITS'(MAX_VERTICES)
                       : vertex_count_ff;

   agl_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_VERTICES * LIST_DEPTH)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_port.wr_en),
      .wr_addr (ent_port.wr_addr),
      .wr_data (ent_port.wr_data),
      .rd_addr (ent_port.rd_addr),
      .rd_data (ent_rd_data)
   );

   agl_ram #(
      .WIDTH (LEN_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_port.wr_en),
      .wr_addr (len_port.wr_addr),
      .wr_data (len_port.wr_data),
      .rd_addr (len_port.rd_addr),
      .rd_data (len_rd_data)
   );

   agl_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .active_count (active_count),
      .ent_port     (ent_port),
      .ent_rd_data  (ent_rd_data),
      .len_port     (len_port),
      .len_rd_data  (len_rd_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for adjacency_list_graph_store_core: directed and random graph requests,
// checked against an in-bench model of the neighbor lists and the vertex_count register.
// Depends on agl_pkg and the core RTL only.
module tb;
   import agl_pkg::*;

   localparam int SETTLE_CYCLES = 160;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    csr_write_enable = 1'b0;
   logic [VALUE_BITS-1:0] csr_write_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   adjacency_list_graph_store_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // graph model
   logic [VALUE_BITS-1:0] neighbor_table [1:MAX_VERTICES][0:LIST_DEPTH-1];
   int unsigned           neighbor_count [1:MAX_VERTICES];
   logic [VALUE_BITS-1:0] vertex_count_setting;
   rsp_type               expected_responses [$];

   int unsigned error_count = 0;
   int unsigned burst_left  = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int unsigned vertices_in_use();
      if (vertex_count_setting == 0) return 1;
      if (vertex_count_setting > MAX_VERTICES) return MAX_VERTICES;
      return int'(vertex_count_setting);
   endfunction

   function automatic bit vertex_valid(int unsigned v);
      return v >= 1 && v <= vertices_in_use();
   endfunction

   function automatic bit list_contains(int unsigned u, int unsigned v);
      for (int j = 0; j < neighbor_count[u]; j++)
         if (neighbor_table[u][j] == v) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void append_neighbor(int unsigned u, int unsigned v);
      neighbor_table[u][neighbor_count[u]] = VALUE_BITS'(v);
      neighbor_count[u]++;
   endfunction

   function automatic void push_response(int unsigned value, logic [1:0] status, logic last);
      rsp_type r;
      r.value  = VALUE_BITS'(value);
      r.status = status;
      r.last   = last;
      expected_responses.push_back(r);
   endfunction

   function automatic req_type make_request(logic [2:0] kind, int unsigned a, int unsigned b);
      req_type r;
      r.kind          = kind;
      r.first_vertex  = VALUE_BITS'(a);
      r.second_vertex = VALUE_BITS'(b);
      return r;
   endfunction

   function automatic void predict_graph_request(req_type r);
      int unsigned a;
      int unsigned b;
      bit          no_room;
      int unsigned found [$];
      a = int'(r.first_vertex);
      b = int'(r.second_vertex);
      case (r.kind)
         KIND_CLEAR: begin
            for (int u = 1; u <= MAX_VERTICES; u++) neighbor_count[u] = 0;
            push_response(0, STATUS_OK, 1'b1);
         end
         KIND_ADD: begin
            if (!vertex_valid(a) || !vertex_valid(b)) begin
               push_response(0, STATUS_RANGE, 1'b1);
            end else begin
               if (a == b) no_room = neighbor_count[a] + 2 > LIST_DEPTH;
               else no_room = neighbor_count[a] >= LIST_DEPTH || neighbor_count[b] >= LIST_DEPTH;
               if (no_room) begin
                  push_response(0, STATUS_FULL, 1'b1);
               end else begin
                  append_neighbor(a, b);
                  append_neighbor(b, a);
                  push_response(0, STATUS_OK, 1'b1);
               end
            end
         end
         KIND_ADJ: begin
            if (!vertex_valid(a) || !vertex_valid(b)) push_response(0, STATUS_RANGE, 1'b1);
            else push_response(int'(list_contains(a, b)), STATUS_OK, 1'b1);
         end
         KIND_DEGREE: begin
            if (!vertex_valid(a)) push_response(0, STATUS_RANGE, 1'b1);
            else push_response(neighbor_count[a], STATUS_OK, 1'b1);
         end
         KIND_LIST: begin
            if (!vertex_valid(a)) begin
               push_response(0, STATUS_RANGE, 1'b1);
            end else begin
               for (int v = 1; v <= vertices_in_use() && found.size() < RESULT_LIMIT; v++)
                  if (list_contains(a, v)) found.push_back(v);
               if (found.size() == 0) push_response(0, STATUS_EMPTY, 1'b1);
               for (int i = 0; i < found.size(); i++)
                  push_response(found[i], STATUS_OK, i == found.size() - 1);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected response, value", int'(rsp_data.value), 0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_data.value !== want.value)
               report_mismatch("value", int'(rsp_data.value), int'(want.value));
            if (rsp_data.status !== want.status)
               report_mismatch("status", int'(rsp_data.status), int'(want.status));
            if (rsp_data.last !== want.last)
               report_mismatch("last", int'(rsp_data.last), int'(want.last));
         end
      end
   end

   // Sends one request in bursts; start stays high across back-to-back requests.
   task automatic send_request(req_type r);
      int unsigned gap;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predict_graph_request(r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(int unsigned count);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= VALUE_BITS'(count);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vertex_count_setting = VALUE_BITS'(count);
   endtask

   function automatic int unsigned random_vertex();
      if ($urandom_range(0, 11) == 0) return $urandom_range(0, 127);
      return $urandom_range(1, vertices_in_use());
   endfunction

   task automatic test_empty_after_reset();
      send_request(make_request(KIND_DEGREE, 1, 0));
      send_request(make_request(KIND_DEGREE, MAX_VERTICES, 0));
      send_request(make_request(KIND_LIST, 1, 0));
      send_request(make_request(KIND_ADJ, 1, MAX_VERTICES));
   endtask

   task automatic test_bad_vertices();
      send_request(make_request(KIND_ADD, 0, 1));
      send_request(make_request(KIND_ADD, 1, MAX_VERTICES + 1));
      send_request(make_request(KIND_ADJ, 127, 1));
      send_request(make_request(KIND_DEGREE, 0, 127));
      send_request(make_request(KIND_LIST, MAX_VERTICES + 1, 0));
      send_request(make_request(KIND_ADD, MAX_VERTICES, 0));
      for (int k = 1; k <= 3; k++)
         send_request(make_request(3'(KIND_LIST + k), $urandom_range(0, 127),
                                   $urandom_range(0, 127)));
   endtask

   task automatic test_edges_and_queries();
      send_request(make_request(KIND_ADD, 1, MAX_VERTICES));
      send_request(make_request(KIND_ADD, 5, 5));
      send_request(make_request(KIND_ADJ, 1, MAX_VERTICES));
      send_request(make_request(KIND_ADJ, MAX_VERTICES, 1));
      send_request(make_request(KIND_ADJ, 2, 3));
      send_request(make_request(KIND_DEGREE, 5, 0));
      send_request(make_request(KIND_LIST, 5, 0));
      send_request(make_request(KIND_LIST, MAX_VERTICES, 0));
      send_request(make_request(KIND_CLEAR, 0, 0));
      send_request(make_request(KIND_DEGREE, 1, 0));
      send_request(make_request(KIND_LIST, 1, 0));
   endtask

   // Fill to one free slot; a self loop overflows, an edge fills it, then edges overflow.
   task automatic test_full_list();
      repeat (LIST_DEPTH / 2 - 1) send_request(make_request(KIND_ADD, 3, 3));
      send_request(make_request(KIND_ADD, 3, 4));
      send_request(make_request(KIND_ADD, 3, 3));
      send_request(make_request(KIND_ADD, 3, 7));
      send_request(make_request(KIND_ADD, 3, 8));
      send_request(make_request(KIND_ADD, 8, 3));
      send_request(make_request(KIND_DEGREE, 3, 0));
      send_request(make_request(KIND_LIST, 3, 0));
      send_request(make_request(KIND_ADJ, 3, 7));
      send_request(make_request(KIND_ADJ, 8, 3));
   endtask

   task automatic test_dense_listing();
      int unsigned order [MAX_VERTICES - 1];
      int unsigned j;
      int unsigned t;
      for (int i = 0; i < MAX_VERTICES - 1; i++) order[i] = (i + 1 < 10) ? i + 1 : i + 2;
      for (int i = MAX_VERTICES - 2; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      send_request(make_request(KIND_CLEAR, 0, 0));
      for (int i = 0; i < MAX_VERTICES - 1; i++)
         send_request(($urandom_range(0, 1) == 0) ? make_request(KIND_ADD, 10, order[i])
                                                  : make_request(KIND_ADD, order[i], 10));
      send_request(make_request(KIND_LIST, 10, 0));
      send_request(make_request(KIND_ADD, 10, 10));
      send_request(make_request(KIND_DEGREE, 10, 0));
   endtask

   // Lowering vertex_count keeps stored entries: degree counts them, listing skips them.
   task automatic test_stale_entries();
      send_request(make_request(KIND_CLEAR, 0, 0));
      send_request(make_request(KIND_ADD, 2, 50));
      send_request(make_request(KIND_ADD, 2, 3));
      write_vertex_count(3);
      send_request(make_request(KIND_DEGREE, 2, 0));
      send_request(make_request(KIND_LIST, 2, 0));
      send_request(make_request(KIND_ADJ, 2, 3));
      send_request(make_request(KIND_ADD, 2, 50));
      send_request(make_request(KIND_LIST, 3, 0));
   endtask

   task automatic test_random_traffic(int unsigned count);
      req_type     r;
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) r.kind = KIND_CLEAR;
         else if (pick < 45) r.kind = KIND_ADD;
         else if (pick < 65) r.kind = KIND_ADJ;
         else if (pick < 80) r.kind = KIND_DEGREE;
         else if (pick < 94) r.kind = KIND_LIST;
         else r.kind = 3'(KIND_LIST + $urandom_range(1, 3));
         r.first_vertex  = VALUE_BITS'(random_vertex());
         r.second_vertex = VALUE_BITS'(random_vertex());
         send_request(r);
      end
   endtask

   initial begin
      vertex_count_setting = VALUE_BITS'(MAX_VERTICES);
      for (int u = 1; u <= MAX_VERTICES; u++) neighbor_count[u] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_after_reset();
      test_bad_vertices();
      test_edges_and_queries();
      test_full_list();
      test_dense_listing();
      test_stale_entries();
      test_random_traffic(6);
      write_vertex_count(0);
      test_random_traffic(6);
      write_vertex_count(6);
      test_random_traffic(8);
      write_vertex_count(127);
      test_random_traffic(4);
      write_vertex_count(MAX_VERTICES);
      test_random_traffic(4);
      write_vertex_count($urandom_range(2, MAX_VERTICES));
      test_random_traffic(4);

      drain_responses();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
